@@ hw/rtl/riq_pkg.sv @@
// riq_pkg: shared constants, codes and types of the rank insert queue.
// No dependencies; imported by every module of the block.
`default_nettype none

package riq_pkg;

   localparam int DEPTH_DEF   = 16;
   localparam int REF_W       = 16;
   localparam int RANK_W      = 8;
   localparam int COUNT_W     = 5;
   localparam int OCC_W       = 5;
   localparam int STATUS_W    = 2;
   localparam int OP_W        = 2;
   localparam int MAX_RESULTS = 16;

   localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_DRAIN  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DRAINED = 2'd3;

   typedef struct packed {
      logic [REF_W-1:0]  name_ref;
      logic [REF_W-1:0]  address_ref;
      logic [REF_W-1:0]  funds_ref;
      logic [RANK_W-1:0] rank;
   } rec_type;

   typedef struct packed {
      logic insert;
      logic drain;
   } chain_cmd_type;

endpackage

`default_nettype wire

@@ hw/rtl/riq_cell.sv @@
// riq_cell: one slot of the record chain; holds, shifts toward the tail,
// shifts toward the head or loads a new record. Depends on riq_pkg.
`default_nettype none

module riq_cell #(
   parameter int INDEX = 0,
   parameter int IW    = 4
) (
   input  wire logic                   clock,
   input  wire riq_pkg::chain_cmd_type cmd,
   input  wire logic [IW-1:0]          pos,
   input  wire riq_pkg::rec_type       new_rec,
   input  wire riq_pkg::rec_type       left_rec,
   input  wire riq_pkg::rec_type       right_rec,
   output riq_pkg::rec_type            rec
);
   import riq_pkg::*;

   rec_type rec_ff;
   rec_type rec_in;

   always_comb begin
      rec_in = rec_ff;
      if (cmd.drain) begin
         rec_in = right_rec;
      end else if (cmd.insert) begin
         if (pos == IW'(INDEX)) begin
            rec_in = new_rec;
         end else if (pos < IW'(INDEX)) begin
            rec_in = left_rec;
         end
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec = rec_ff;

endmodule

`default_nettype wire

@@ hw/rtl/rank_insert_queue.sv @@
// rank_insert_queue: ordered record queue built as a chain of riq_cell slots,
// with insert by rank and multi-word drain. Depends on riq_pkg, riq_cell.
//
//   channel | dir | words              | handshake
//   req_    | in  | one operation      | req_valid / req_stall
//   rsp_    | out | one result per row | rsp_valid / rsp_stall
//
// Append and insert shift the chain in the cycle they are taken, unless full.
// A drain enters the drain state, then yields one word per cycle unless stalled.
// req_stall is high while a drain runs or the result register is held.
// Synchronous active-high reset empties the queue; slot contents are not cleared.
`default_nettype none

module rank_insert_queue #(
   parameter int DEPTH = riq_pkg::DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [riq_pkg::OP_W-1:0]      req_operation,
   input  wire logic [riq_pkg::REF_W-1:0]     req_name_ref,
   input  wire logic [riq_pkg::REF_W-1:0]     req_address_ref,
   input  wire logic [riq_pkg::REF_W-1:0]     req_funds_ref,
   input  wire logic [riq_pkg::RANK_W-1:0]    req_rank,
   input  wire logic [riq_pkg::COUNT_W-1:0]   req_count,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [riq_pkg::STATUS_W-1:0]       rsp_status,
   output logic [riq_pkg::REF_W-1:0]          rsp_out_name_ref,
   output logic [riq_pkg::REF_W-1:0]          rsp_out_address_ref,
   output logic [riq_pkg::REF_W-1:0]          rsp_out_funds_ref,
   output logic [riq_pkg::RANK_W-1:0]         rsp_out_rank,
   output logic [riq_pkg::OCC_W-1:0]          rsp_occupancy,
   output logic                               rsp_last_of_run
);
   import riq_pkg::*;

   localparam int HW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);
   localparam int CW = (HW > OCC_W) ? HW : OCC_W;
   localparam int PW = (HW > RANK_W) ? HW : RANK_W;

   localparam logic STATE_IDLE  = 1'b0;
   localparam logic STATE_DRAIN = 1'b1;

   logic                state_ff, state_in;
   logic [HW-1:0]       held_ff, held_in;
   logic [COUNT_W-1:0]  drain_left_ff, drain_left_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_load;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   rec_type             rsp_rec_ff, rsp_rec_in;
   logic [HW-1:0]       rsp_held_ff, rsp_held_in;
   logic                rsp_last_ff, rsp_last_in;

   chain_cmd_type       cmd;
   rec_type             new_rec;
   rec_type             cell_rec [DEPTH];

   logic                out_free, take, drain_step, full, empty;
   logic [PW-1:0]       held_p, rank_p, pos_p;
   logic [IW-1:0]       pos;
   logic [COUNT_W-1:0]  cnt_cap, run_len;
   logic [CW-1:0]       held_c, occ_wide;

   assign new_rec.name_ref    = req_name_ref;
   assign new_rec.address_ref = req_address_ref;
   assign new_rec.funds_ref   = req_funds_ref;
   assign new_rec.rank        = req_rank;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != STATE_IDLE) || !out_free;
   assign take       = req_valid && !req_stall;
   assign drain_step = (state_ff == STATE_DRAIN) && out_free;
   assign full       = (held_ff == HW'(DEPTH));
   assign empty      = (held_ff == '0);

   // slot index of the new record
   assign held_p = PW'(held_ff);
   assign rank_p = PW'(req_rank);
   always_comb begin
      if (req_operation == OP_APPEND || empty) begin
         pos_p = held_p;
      end else if (rank_p <= PW'(1)) begin
         pos_p = '0;
      end else if (rank_p > held_p) begin
         pos_p = held_p;
      end else begin
         pos_p = rank_p - PW'(1);
      end
   end
   assign pos = pos_p[IW-1:0];

   assign cnt_cap = (req_count > COUNT_W'(MAX_RESULTS)) ? COUNT_W'(MAX_RESULTS) : req_count;
   assign held_c  = CW'(held_ff);
   assign run_len = (held_c < CW'(cnt_cap)) ? held_c[COUNT_W-1:0] : cnt_cap;

   always_comb begin
      state_in      = state_ff;
      held_in       = held_ff;
      drain_left_in = drain_left_ff;
      cmd           = '0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_load      = 1'b0;
      rsp_status_in = ST_OK;
      rsp_rec_in    = '0;
      rsp_held_in   = held_ff;
      rsp_last_in   = 1'b1;

      if (take) begin
         case (req_operation)
            OP_APPEND, OP_INSERT: begin
               rsp_load = 1'b1;
               if (full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  cmd.insert    = 1'b1;
                  held_in       = held_ff + HW'(1);
                  rsp_held_in   = held_ff + HW'(1);
                  rsp_status_in = ST_OK;
               end
            end
            OP_DRAIN: begin
               if (empty) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = ST_EMPTY;
               end else if (run_len != '0) begin
                  state_in      = STATE_DRAIN;
                  drain_left_in = run_len;
               end
            end
            default: begin
            end
         endcase
      end

      if (drain_step) begin
         cmd.drain     = 1'b1;
         held_in       = held_ff - HW'(1);
         rsp_load      = 1'b1;
         rsp_status_in = ST_DRAINED;
         rsp_rec_in    = cell_rec[0];
         rsp_held_in   = held_ff - HW'(1);
         rsp_last_in   = (drain_left_ff == COUNT_W'(1));
         drain_left_in = drain_left_ff - COUNT_W'(1);
         if (drain_left_ff == COUNT_W'(1)) begin
            state_in = STATE_IDLE;
         end
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= STATE_IDLE;
         held_ff       <= '0;
         drain_left_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_ff       <= held_in;
         drain_left_ff <= drain_left_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_rec_ff    <= rsp_rec_in;
         rsp_held_ff   <= rsp_held_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // record chain, head at slot 0
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      rec_type left_rec, right_rec;
      if (i == 0) begin : g_head
         assign left_rec = new_rec;
      end else begin : g_body
         assign left_rec = cell_rec[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_rec = new_rec;
      end else begin : g_inner
         assign right_rec = cell_rec[i+1];
      end
      riq_cell #(
         .INDEX (i),
         .IW    (IW)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .pos       (pos),
         .new_rec   (new_rec),
         .left_rec  (left_rec),
         .right_rec (right_rec),
         .rec       (cell_rec[i])
      );
   end

   assign occ_wide            = CW'(rsp_held_ff);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_out_name_ref    = rsp_rec_ff.name_ref;
   assign rsp_out_address_ref = rsp_rec_ff.address_ref;
   assign rsp_out_funds_ref   = rsp_rec_ff.funds_ref;
   assign rsp_out_rank        = rsp_rec_ff.rank;
   assign rsp_occupancy       = occ_wide[OCC_W-1:0];
   assign rsp_last_of_run     = rsp_last_ff;

endmodule

`default_nettype wire

@@ hw/rtl/riq_check.sv @@
// riq_check: port-level assertions for rank_insert_queue, bound to the top level.
// Depends on riq_pkg.
`default_nettype none

module riq_check (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [riq_pkg::STATUS_W-1:0]  rsp_status,
   input wire logic [riq_pkg::REF_W-1:0]     rsp_out_name_ref,
   input wire logic [riq_pkg::REF_W-1:0]     rsp_out_address_ref,
   input wire logic [riq_pkg::REF_W-1:0]     rsp_out_funds_ref,
   input wire logic [riq_pkg::RANK_W-1:0]    rsp_out_rank,
   input wire logic [riq_pkg::OCC_W-1:0]     rsp_occupancy,
   input wire logic                          rsp_last_of_run
);
   import riq_pkg::*;

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_occupancy == '0 && rsp_last_of_run))
      else $error("empty status with nonzero occupancy or open run");

   a_single_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_DRAINED) |->
      (rsp_last_of_run && rsp_out_name_ref == '0 && rsp_out_address_ref == '0 &&
       rsp_out_funds_ref == '0 && rsp_out_rank == '0))
      else $error("non-drain word carries record data or open run");

   a_drain_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_status == ST_DRAINED && !rsp_last_of_run) |=>
      (rsp_valid && rsp_status == ST_DRAINED &&
       rsp_occupancy == OCC_W'($past(rsp_occupancy) - OCC_W'(1))))
      else $error("drain run broken or occupancy not stepping down");

endmodule

bind rank_insert_queue riq_check u_riq_check (.*);

`default_nettype wire

@@ verif/rank_insert_queue_chk.sv @@
// rank_insert_queue_chk: watches the req_ and rsp_ channels of the rank insert queue,
// predicts every result word from the accepted operations and compares field by field.
// Depends on riq_pkg.
module rank_insert_queue_chk #(
   parameter int DEPTH = riq_pkg::DEPTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic                         req_stall,
   input  wire logic [riq_pkg::OP_W-1:0]     req_operation,
   input  wire logic [riq_pkg::REF_W-1:0]    req_name_ref,
   input  wire logic [riq_pkg::REF_W-1:0]    req_address_ref,
   input  wire logic [riq_pkg::REF_W-1:0]    req_funds_ref,
   input  wire logic [riq_pkg::RANK_W-1:0]   req_rank,
   input  wire logic [riq_pkg::COUNT_W-1:0]  req_count,
   input  wire logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   input  wire logic [riq_pkg::STATUS_W-1:0] rsp_status,
   input  wire logic [riq_pkg::REF_W-1:0]    rsp_out_name_ref,
   input  wire logic [riq_pkg::REF_W-1:0]    rsp_out_address_ref,
   input  wire logic [riq_pkg::REF_W-1:0]    rsp_out_funds_ref,
   input  wire logic [riq_pkg::RANK_W-1:0]   rsp_out_rank,
   input  wire logic [riq_pkg::OCC_W-1:0]    rsp_occupancy,
   input  wire logic                         rsp_last_of_run,
   output int                                fail_count,
   output int                                words_due
);
   timeunit 1ns;
   timeprecision 1ps;
   import riq_pkg::*;

   typedef struct {
      logic [STATUS_W-1:0] status;
      rec_type             rec;
      logic [OCC_W-1:0]    occupancy;
      logic                last;
   } result_word_type;

   rec_type         queued_recs[$];
   result_word_type due_words[$];

   function automatic void push_word(logic [STATUS_W-1:0] status, rec_type rec, logic last);
      result_word_type w;
      w.status    = status;
      w.rec       = rec;
      w.occupancy = OCC_W'(queued_recs.size());
      w.last      = last;
      due_words.push_back(w);
   endfunction

   function automatic void apply_operation(logic [OP_W-1:0] op, rec_type rec,
                                           logic [COUNT_W-1:0] cnt);
      int      pos;
      int      n;
      rec_type head;
      case (op)
         OP_APPEND, OP_INSERT: begin
            if (queued_recs.size() >= DEPTH) begin
               push_word(ST_FULL, '0, 1'b1);
            end else begin
               if (op == OP_APPEND) begin
                  pos = queued_recs.size();
               end else if (queued_recs.size() == 0 || rec.rank <= 1) begin
                  pos = 0;
               end else if (rec.rank > queued_recs.size()) begin
                  pos = queued_recs.size();
               end else begin
                  pos = rec.rank - 1;
               end
               queued_recs.insert(pos, rec);
               push_word(ST_OK, '0, 1'b1);
            end
         end
         OP_DRAIN: begin
            if (queued_recs.size() == 0) begin
               push_word(ST_EMPTY, '0, 1'b1);
            end else begin
               n = cnt;
               if (n > queued_recs.size()) n = queued_recs.size();
               if (n > MAX_RESULTS) n = MAX_RESULTS;
               for (int i = 0; i < n; i++) begin
                  head = queued_recs.pop_front();
                  push_word(ST_DRAINED, head, i == n - 1);
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(string field, logic [15:0] expected,
                                       logic [15:0] actual);
      if (actual !== expected) begin
         $error("%s: expected %0h, actual %0h", field, expected, actual);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      result_word_type w;
      rec_type         rec;
      if (reset) begin
         queued_recs.delete();
         due_words.delete();
      end else begin
         if (req_valid && !req_stall) begin
            rec.name_ref    = req_name_ref;
            rec.address_ref = req_address_ref;
            rec.funds_ref   = req_funds_ref;
            rec.rank        = req_rank;
            apply_operation(req_operation, rec, req_count);
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_words.size() == 0) begin
               $error("result word with none expected: status %0h", rsp_status);
               fail_count++;
            end else begin
               w = due_words.pop_front();
               check_field("status", 16'(w.status), 16'(rsp_status));
               check_field("out_name_ref", w.rec.name_ref, rsp_out_name_ref);
               check_field("out_address_ref", w.rec.address_ref, rsp_out_address_ref);
               check_field("out_funds_ref", w.rec.funds_ref, rsp_out_funds_ref);
               check_field("out_rank", 16'(w.rec.rank), 16'(rsp_out_rank));
               check_field("occupancy", 16'(w.occupancy), 16'(rsp_occupancy));
               check_field("last_of_run", 16'(w.last), 16'(rsp_last_of_run));
            end
         end
      end
      words_due = due_words.size();
   end

endmodule

@@ verif/rank_insert_queue_tb.sv @@
// rank_insert_queue_tb: drives directed and random operations into the rank insert
// queue with random sender gaps and receiver stalls. Depends on riq_pkg,
// rank_insert_queue and rank_insert_queue_chk.
module rank_insert_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import riq_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_operation = '0;
   logic [REF_W-1:0]    req_name_ref = '0;
   logic [REF_W-1:0]    req_address_ref = '0;
   logic [REF_W-1:0]    req_funds_ref = '0;
   logic [RANK_W-1:0]   req_rank = '0;
   logic [COUNT_W-1:0]  req_count = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [REF_W-1:0]    rsp_out_name_ref;
   logic [REF_W-1:0]    rsp_out_address_ref;
   logic [REF_W-1:0]    rsp_out_funds_ref;
   logic [RANK_W-1:0]   rsp_out_rank;
   logic [OCC_W-1:0]    rsp_occupancy;
   logic                rsp_last_of_run;
   int                  fail_count;
   int                  words_due;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles   = 0;

   rank_insert_queue #(.DEPTH(DEPTH_DEF)) u_top (.*);

   rank_insert_queue_chk #(.DEPTH(DEPTH_DEF)) u_chk (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("rank_insert_queue_tb: FAIL");
      $finish;
   end

   // receiver: random stalls, or a long hold-off when hold_cycles is set
   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   task automatic send_word(logic [OP_W-1:0] op, logic [REF_W-1:0] name_ref,
                            logic [REF_W-1:0] address_ref, logic [REF_W-1:0] funds_ref,
                            logic [RANK_W-1:0] rank, logic [COUNT_W-1:0] cnt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_name_ref    <= name_ref;
      req_address_ref <= address_ref;
      req_funds_ref   <= funds_ref;
      req_rank        <= rank;
      req_count       <= cnt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic random_word();
      logic [OP_W-1:0]    op;
      logic [RANK_W-1:0]  rank;
      logic [COUNT_W-1:0] cnt;
      int                 pick;
      pick = $urandom_range(99);
      if (pick < 36) op = OP_APPEND;
      else if (pick < 72) op = OP_INSERT;
      else if (pick < 96) op = OP_DRAIN;
      else op = OP_UNUSED;
      // ranks mostly near the occupancy so that mid-queue inserts happen often
      rank = RANK_W'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(18));
      cnt  = COUNT_W'(($urandom_range(7) == 0) ? $urandom_range(16) : $urandom_range(5));
      send_word(op, REF_W'($urandom_range(65535)), REF_W'($urandom_range(65535)),
                REF_W'($urandom_range(65535)), rank, cnt);
   endtask

   task automatic wait_all_words();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (words_due == 0);
      @(posedge clock);
   endtask

   task automatic random_phase(int send_pct, int recv_pct, int n);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (n) random_word();
      wait_all_words();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 20;
      recv_idle_pct = 72;
      send_word(OP_DRAIN, '0, '0, '0, '0, 5'd0);
      send_word(OP_DRAIN, '1, '1, '1, '1, 5'd16);
      send_word(OP_INSERT, 16'h1111, 16'h2222, 16'h3333, 8'd200, 5'd0);
      send_word(OP_INSERT, 16'h4444, 16'h5555, 16'h6666, 8'd0, 5'd0);
      send_word(OP_INSERT, 16'h7777, 16'h8888, 16'h9999, 8'd1, 5'd0);
      send_word(OP_APPEND, '1, '1, '1, '1, 5'd16);
      send_word(OP_APPEND, '0, '0, '0, '0, 5'd0);
      send_word(OP_INSERT, 16'hA5A5, 16'h5A5A, 16'h0F0F, 8'd3, 5'd0);
      send_word(OP_INSERT, 16'hF0F0, 16'h1234, 16'h5678, 8'd6, 5'd0);
      send_word(OP_INSERT, 16'hBEEF, 16'hCAFE, 16'hD00D, 8'd8, 5'd0);
      send_word(OP_INSERT, 16'h0001, 16'h8000, 16'h7FFF, 8'd255, 5'd0);
      send_word(OP_DRAIN, 16'h1357, 16'h2468, 16'h9BDF, 8'd4, 5'd0);
      send_word(OP_UNUSED, 16'hFFFF, 16'h0000, 16'hFFFF, 8'd2, 5'd3);
      repeat (7) send_word(OP_APPEND, REF_W'($urandom_range(65535)),
                           REF_W'($urandom_range(65535)), REF_W'($urandom_range(65535)),
                           RANK_W'($urandom_range(255)), 5'd0);
      send_word(OP_APPEND, 16'hDEAD, 16'hDEAD, 16'hDEAD, 8'd9, 5'd0);
      send_word(OP_INSERT, 16'hFACE, 16'hFACE, 16'hFACE, 8'd2, 5'd0);
      send_word(OP_DRAIN, '0, '0, '0, '0, 5'd16);
      send_word(OP_DRAIN, '0, '0, '0, '0, 5'd5);
      wait_all_words();

      random_phase(20, 72, 130);
      random_phase(72, 20, 130);

      // long receiver hold-off with a steady sender: the held result word stalls req_
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles = 300;
      repeat (40) random_word();
      random_phase(0, 0, 100);

      repeat (32) @(posedge clock);
      if (fail_count == 0) begin
         $display("rank_insert_queue_tb: PASS");
      end else begin
         $display("rank_insert_queue_tb: FAIL");
      end
      $finish;
   end

endmodule
